/* rtl/core/hbm_pkg.sv */
package hbm_pkg;

   // Number format: signed Q15.16
   localparam int DATA_W = 32;
   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   // Three spatial columns, one divider lane each
   localparam int NUM_LANES = 3;

   // Quotient bits per division; larger quotients saturate
   localparam int QUO_W = 33;
   localparam int DIV_STEPS = QUO_W;
   // Product magnitude width (|t| <= 2^31, so |t_k * t_j| <= 2^62)
   localparam int PROD_W = 63;
   // Lane registers: operands, product, setup, one per quotient bit, result
   localparam int LANE_DEPTH = DIV_STEPS + 4;

   // Row codes
   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd3;

   // Command codes
   localparam logic CMD_FORWARD = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   // Classified point waiting between front and back
   typedef struct packed {
      logic                                inverse;
      logic                                bad;
      logic [DATA_W-1:0]                   den;
      logic [NUM_LANES-1:0][DATA_W-1:0]    mag;
      logic [NUM_LANES-1:0]                sgn;
      logic [DATA_W-1:0]                   coord_w;
   } item_type;

   // Operands of one lane for one row
   typedef struct packed {
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic [DATA_W-1:0] den;
      logic              neg;
      logic              diag;
   } op_type;

   // Row bookkeeping that travels beside the lanes
   typedef struct packed {
      logic [1:0]        row_index;
      logic [DATA_W-1:0] col3;
      logic              bad;
   } sb_type;

   // One matrix row as delivered
   typedef struct packed {
      logic [1:0]        row_index;
      logic [DATA_W-1:0] entry_col0;
      logic [DATA_W-1:0] entry_col1;
      logic [DATA_W-1:0] entry_col2;
      logic [DATA_W-1:0] entry_col3;
      logic              last_row;
      logic              bad_point;
   } result_type;

endpackage

/* rtl/core/hyperboloid_boost_matrix_unit.sv */
// Channel | Handshake         | Payload
// req     | req_push/req_full | req_command, req_coord_x/y/z/w
// rsp     | rsp_pop/rsp_empty | rsp_row_index, rsp_entry_col0..3, rsp_last_row, rsp_bad_point
//
// Each transaction yields four row transactions; the row sequencer issues one row
// per cycle into three divider lanes while an item waits and the back pipe advances.
// Rows pass through a 33-step restoring divide. A full result queue freezes the back
// pipe while a finished row waits at its end; req stays open until the item queue fills.
// Reset is synchronous: clears both queues, the row counter and pipe valid bits.
module hyperboloid_boost_matrix_unit #(
   parameter int ITEM_QUEUE_DEPTH   = 2,
   parameter int RESULT_QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_command,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic signed [31:0] req_coord_w,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_entry_col0,
   output logic signed [31:0] rsp_entry_col1,
   output logic signed [31:0] rsp_entry_col2,
   output logic signed [31:0] rsp_entry_col3,
   output logic               rsp_last_row,
   output logic               rsp_bad_point
);

   hbm_pkg::item_type   item_w;
   hbm_pkg::item_type   item_head;
   logic                item_empty;
   logic                item_pop;
   hbm_pkg::result_type row_w;
   hbm_pkg::result_type row_head;
   logic                row_push;
   logic                row_full;

   // Front: classify the point
   hbm_front u_front (
      .req_command (req_command),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .req_coord_w (req_coord_w),
      .item        (item_w)
   );

   // Queue between front and back
   hbm_queue #(
      .DEPTH (ITEM_QUEUE_DEPTH),
      .WIDTH ($bits(hbm_pkg::item_type))
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (item_w),
      .full  (req_full),
      .pop   (item_pop),
      .rdata (item_head),
      .empty (item_empty)
   );

   // Back: row sequencer and divider lanes
   hbm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item_head),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .rsp_full   (row_full),
      .rsp_push   (row_push),
      .rsp_data   (row_w)
   );

   // Result queue
   hbm_queue #(
      .DEPTH (RESULT_QUEUE_DEPTH),
      .WIDTH ($bits(hbm_pkg::result_type))
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (row_push),
      .wdata (row_w),
      .full  (row_full),
      .pop   (rsp_pop),
      .rdata (row_head),
      .empty (rsp_empty)
   );

   assign rsp_row_index  = row_head.row_index;
   assign rsp_entry_col0 = row_head.entry_col0;
   assign rsp_entry_col1 = row_head.entry_col1;
   assign rsp_entry_col2 = row_head.entry_col2;
   assign rsp_entry_col3 = row_head.entry_col3;
   assign rsp_last_row   = row_head.last_row;
   assign rsp_bad_point  = row_head.bad_point;

endmodule

/* rtl/core/hbm_queue.sv */
module hbm_queue #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (count_ff == '0 || count_ff == CNT_FULL))
      else $error("queue pointers disagree with count");

endmodule

/* rtl/core/hbm_front.sv */
module hbm_front (
   input  logic              req_command,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic signed [31:0] req_coord_w,
   output hbm_pkg::item_type item
);

   logic signed [32:0]                                   den_s;
   logic [hbm_pkg::NUM_LANES-1:0][hbm_pkg::DATA_W-1:0]   coord;

   assign coord[0] = req_coord_x;
   assign coord[1] = req_coord_y;
   assign coord[2] = req_coord_z;

   // Denominator w + 1 and the bad-point check
   assign den_s = {req_coord_w[31], req_coord_w} + 33'sh0_0001_0000;

   always_comb begin
      item.inverse = (req_command == hbm_pkg::CMD_INVERSE);
      item.bad     = den_s[32] || (den_s == '0);
      item.den     = item.bad ? 32'd1 : den_s[31:0];
      item.coord_w = req_coord_w;
      // Split x, y, z into sign and magnitude (most negative gives 2^31)
      for (int j = 0; j < hbm_pkg::NUM_LANES; j++) begin
         item.sgn[j] = coord[j][31];
         item.mag[j] = coord[j][31] ? (~coord[j] + 32'd1) : coord[j];
      end
   end

endmodule

/* rtl/core/hbm_lane.sv */
module hbm_lane (
   input  logic                        clock,
   input  logic                        advance,
   input  hbm_pkg::op_type             op,
   output logic [hbm_pkg::DATA_W-1:0]  entry
);

   localparam int QW = hbm_pkg::QUO_W;
   localparam logic signed [QW+1:0] SUM_MAX = (QW+2)'(64'sd2147483647);
   localparam logic signed [QW+1:0] SUM_MIN = (QW+2)'(-64'sd2147483648);

   typedef struct packed {
      logic [hbm_pkg::PROD_W-1:0] prod;
      logic [hbm_pkg::DATA_W-1:0] den;
      logic                       neg;
      logic                       diag;
   } prod_type;

   typedef struct packed {
      logic [hbm_pkg::DATA_W-1:0] rem;
      logic [QW-1:0]              quo;
      logic [hbm_pkg::DATA_W-1:0] den;
      logic                       neg;
      logic                       diag;
      logic                       ovf;
   } step_type;

   hbm_pkg::op_type            op_ff;
   prod_type                   prod_ff, prod_in;
   step_type                   step_ff [hbm_pkg::DIV_STEPS+1];
   step_type                   step_in [hbm_pkg::DIV_STEPS+1];
   logic [hbm_pkg::DATA_W-1:0] result_ff, result_in;

   // Magnitude product
   always_comb begin
      logic [63:0] full_prod;
      full_prod    = {32'b0, op_ff.mag_a} * {32'b0, op_ff.mag_b};
      prod_in.prod = full_prod[hbm_pkg::PROD_W-1:0];
      prod_in.den  = op_ff.den;
      prod_in.neg  = op_ff.neg;
      prod_in.diag = op_ff.diag;
   end

   // Divider setup and one restoring step per quotient bit
   always_comb begin
      logic [32:0] r2;
      logic [33:0] diff;
      logic        ge;
      step_in[0].rem  = {2'b00, prod_ff.prod[hbm_pkg::PROD_W-1:QW]};
      step_in[0].quo  = prod_ff.prod[QW-1:0];
      step_in[0].den  = prod_ff.den;
      step_in[0].neg  = prod_ff.neg;
      step_in[0].diag = prod_ff.diag;
      // quotient would need more than QW bits
      step_in[0].ovf  = ({2'b00, prod_ff.prod[hbm_pkg::PROD_W-1:QW]} >= prod_ff.den);
      for (int i = 0; i < hbm_pkg::DIV_STEPS; i++) begin
         r2   = {step_ff[i].rem, step_ff[i].quo[QW-1]};
         diff = {1'b0, r2} - {2'b00, step_ff[i].den};
         ge   = !diff[33];
         step_in[i+1]     = step_ff[i];
         step_in[i+1].rem = ge ? diff[31:0] : r2[31:0];
         step_in[i+1].quo = {step_ff[i].quo[QW-2:0], ge};
      end
   end

   // Sign, identity term and saturation
   always_comb begin
      logic signed [QW+1:0] delta;
      logic signed [QW+1:0] q_ext;
      logic signed [QW+1:0] sum;
      delta = step_ff[hbm_pkg::DIV_STEPS].diag ? (QW+2)'(hbm_pkg::ONE_Q16) : '0;
      q_ext = {2'b00, step_ff[hbm_pkg::DIV_STEPS].quo};
      sum   = step_ff[hbm_pkg::DIV_STEPS].neg ? (delta - q_ext) : (delta + q_ext);
      priority if (step_ff[hbm_pkg::DIV_STEPS].ovf) begin
         result_in = step_ff[hbm_pkg::DIV_STEPS].neg ? hbm_pkg::SAT_MIN : hbm_pkg::SAT_MAX;
      end else if (sum > SUM_MAX) begin
         result_in = hbm_pkg::SAT_MAX;
      end else if (sum < SUM_MIN) begin
         result_in = hbm_pkg::SAT_MIN;
      end else begin
         result_in = sum[hbm_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff   <= op;
         prod_ff <= prod_in;
         for (int i = 0; i <= hbm_pkg::DIV_STEPS; i++) begin
            step_ff[i] <= step_in[i];
         end
         result_ff <= result_in;
      end
   end

   assign entry = result_ff;

endmodule

/* rtl/core/hbm_back.sv */
module hbm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hbm_pkg::item_type    item,
   input  logic                 item_empty,
   output logic                 item_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output hbm_pkg::result_type  rsp_data
);

   localparam int SB_LAST = hbm_pkg::LANE_DEPTH - 1;

   logic [1:0]                  row_ff, row_in;
   logic                        sb_valid_ff [hbm_pkg::LANE_DEPTH];
   hbm_pkg::sb_type             sb_ff [hbm_pkg::LANE_DEPTH];
   hbm_pkg::sb_type             sb_new;
   hbm_pkg::op_type             lane_op [hbm_pkg::NUM_LANES];
   logic [hbm_pkg::DATA_W-1:0]  lane_entry [hbm_pkg::NUM_LANES];
   logic                        advance;
   logic                        issue;

   // Whole pipe holds only when a finished row cannot enter the result queue
   assign advance  = !sb_valid_ff[SB_LAST] || !rsp_full;
   assign issue    = advance && !item_empty;
   assign item_pop = issue && (row_ff == hbm_pkg::ROW_LAST);
   assign row_in   = issue ? row_ff + 2'd1 : row_ff;

   // Row issue: lane operands and column 3
   always_comb begin
      logic neg3;
      neg3 = 1'b0;
      for (int j = 0; j < hbm_pkg::NUM_LANES; j++) begin
         if (row_ff == hbm_pkg::ROW_LAST) begin
            // pass +-t_j through the lane (divide by one)
            lane_op[j].mag_a = item.mag[j];
            lane_op[j].mag_b = 32'd1;
            lane_op[j].den   = 32'd1;
            lane_op[j].neg   = item.sgn[j] ^ item.inverse;
            lane_op[j].diag  = 1'b0;
         end else begin
            lane_op[j].mag_a = item.mag[row_ff];
            lane_op[j].mag_b = item.bad ? '0 : item.mag[j];
            lane_op[j].den   = item.den;
            lane_op[j].neg   = item.sgn[row_ff] ^ item.sgn[j];
            lane_op[j].diag  = (row_ff == 2'(j));
         end
      end
      sb_new.row_index = row_ff;
      sb_new.bad       = item.bad;
      if (row_ff == hbm_pkg::ROW_LAST) begin
         sb_new.col3 = item.coord_w;
      end else begin
         neg3 = item.sgn[row_ff] ^ item.inverse;
         if (neg3) begin
            sb_new.col3 = ~item.mag[row_ff] + 32'd1;
         end else if (item.mag[row_ff][31]) begin
            sb_new.col3 = hbm_pkg::SAT_MAX;
         end else begin
            sb_new.col3 = item.mag[row_ff];
         end
      end
   end

   // Row counter and valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= hbm_pkg::ROW_FIRST;
         for (int i = 0; i < hbm_pkg::LANE_DEPTH; i++) begin
            sb_valid_ff[i] <= 1'b0;
         end
      end else begin
         row_ff <= row_in;
         if (advance) begin
            sb_valid_ff[0] <= issue;
            for (int i = 1; i < hbm_pkg::LANE_DEPTH; i++) begin
               sb_valid_ff[i] <= sb_valid_ff[i-1];
            end
         end
      end
   end

   // Row bookkeeping beside the lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[0] <= sb_new;
         for (int i = 1; i < hbm_pkg::LANE_DEPTH; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   // Divider lanes, one per spatial column
   for (genvar j = 0; j < hbm_pkg::NUM_LANES; j++) begin : g_lane
      hbm_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .op      (lane_op[j]),
         .entry   (lane_entry[j])
      );
   end

   // Finished row
   assign rsp_push            = sb_valid_ff[SB_LAST] && advance;
   assign rsp_data.row_index  = sb_ff[SB_LAST].row_index;
   assign rsp_data.entry_col0 = lane_entry[0];
   assign rsp_data.entry_col1 = lane_entry[1];
   assign rsp_data.entry_col2 = lane_entry[2];
   assign rsp_data.entry_col3 = sb_ff[SB_LAST].col3;
   assign rsp_data.last_row   = (sb_ff[SB_LAST].row_index == hbm_pkg::ROW_LAST);
   assign rsp_data.bad_point  = sb_ff[SB_LAST].bad;

   a_row_holds: assert property (@(posedge clock) disable iff (reset)
      !issue |=> (row_ff == $past(row_ff)))
      else $error("row counter moved without issue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("row pushed into full result queue");

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (sb_valid_ff[SB_LAST] && !advance) |=>
         (sb_valid_ff[SB_LAST] && (sb_ff[SB_LAST] == $past(sb_ff[SB_LAST]))))
      else $error("stalled row lost or changed");

endmodule
